// ===== sv/vector_magnitude_sqrt_macros.svh =====
// assertion macros shared by the checker files of vector_magnitude_sqrt
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef VECTOR_MAGNITUDE_SQRT_MACROS_SVH
`define VECTOR_MAGNITUDE_SQRT_MACROS_SVH

// same-cycle implication, disabled during reset
`define VMS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vector_magnitude_sqrt assertion failed");

// next-cycle implication, disabled during reset
`define VMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vector_magnitude_sqrt assertion failed");

`endif

// ===== sv/vms_pkg.sv =====
// shared types, constants and helpers for vector_magnitude_sqrt
// no dependencies; used by vms_ctrl, vms_dp and the top level
`timescale 1ns / 1ps

package vms_pkg;

  // polynomial and scaling coefficients
  localparam logic [15:0] K_A000 = 16'hA000;
  localparam logic [15:0] K_B333 = 16'hB333;
  localparam logic [15:0] K_B505 = 16'hB505;
  localparam logic [31:0] K_ROUND = 32'h0000_8000;

  // datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_SQ_X,
    OP_SQ_Y,
    OP_NORM16,
    OP_NORM8,
    OP_NORM4,
    OP_NORM2,
    OP_NORM1,
    OP_P_INIT,
    OP_TP18,
    OP_TP17,
    OP_TP16,
    OP_MUL_A,
    OP_EP,
    OP_MUL_B,
    OP_SQ_E,
    OP_CORR,
    OP_SHIFT,
    OP_ROUND,
    OP_SMALL,
    OP_EMIT
  } dp_op_t;

  // controller states, one per datapath step; ST_N16 also issues the small-sum step
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ_X,
    ST_SQ_Y,
    ST_N16,
    ST_N8,
    ST_N4,
    ST_N2,
    ST_N1,
    ST_P_INIT,
    ST_TP18,
    ST_TP17,
    ST_TP16,
    ST_MUL_A,
    ST_EP,
    ST_MUL_B,
    ST_SQ_E,
    ST_CORR,
    ST_SHIFT,
    ST_ROUND,
    ST_EMIT
  } vms_state_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic s_small;  // sum is 0 or 1
    logic n_odd;    // normalize count is odd
  } dp_status_t;

  // magnitude of a signed 16-bit value; -32768 maps to 32768
  function automatic logic [15:0] abs16(input logic [15:0] v);
    logic [15:0] r;
    r = v[15] ? (~v + 16'd1) : v;
    return r;
  endfunction

endpackage

// ===== sv/vms_ctrl.sv =====
// sequencer for vector_magnitude_sqrt: walks the datapath through its steps
// depends on vms_pkg; drives vms_dp through dp_cmd_t and reads dp_status_t
`timescale 1ns / 1ps

module vms_ctrl
  import vms_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  vms_state_t state, state_next;
  logic       out_valid_next;
  logic       emit;

  // state and output valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // next state and command
  always_comb begin
    state_next = state;
    cmd.op     = OP_NOP;
    emit       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = ST_SQ_X;
        end
      end
      ST_SQ_X: begin
        cmd.op     = OP_SQ_X;
        state_next = ST_SQ_Y;
      end
      ST_SQ_Y: begin
        cmd.op     = OP_SQ_Y;
        state_next = ST_N16;
      end
      ST_N16: begin
        if (status.s_small) begin
          cmd.op     = OP_SMALL;
          state_next = ST_EMIT;
        end else begin
          cmd.op     = OP_NORM16;
          state_next = ST_N8;
        end
      end
      ST_N8: begin
        cmd.op     = OP_NORM8;
        state_next = ST_N4;
      end
      ST_N4: begin
        cmd.op     = OP_NORM4;
        state_next = ST_N2;
      end
      ST_N2: begin
        cmd.op     = OP_NORM2;
        state_next = ST_N1;
      end
      ST_N1: begin
        cmd.op     = OP_NORM1;
        state_next = ST_P_INIT;
      end
      ST_P_INIT: begin
        cmd.op     = OP_P_INIT;
        state_next = ST_TP18;
      end
      ST_TP18: begin
        cmd.op     = OP_TP18;
        state_next = ST_TP17;
      end
      ST_TP17: begin
        cmd.op     = OP_TP17;
        state_next = ST_TP16;
      end
      ST_TP16: begin
        cmd.op     = OP_TP16;
        state_next = ST_MUL_A;
      end
      ST_MUL_A: begin
        cmd.op     = OP_MUL_A;
        state_next = ST_EP;
      end
      ST_EP: begin
        cmd.op     = OP_EP;
        state_next = ST_MUL_B;
      end
      ST_MUL_B: begin
        cmd.op     = OP_MUL_B;
        state_next = ST_SQ_E;
      end
      ST_SQ_E: begin
        cmd.op     = OP_SQ_E;
        state_next = ST_CORR;
      end
      ST_CORR: begin
        cmd.op     = OP_CORR;
        state_next = ST_SHIFT;
      end
      ST_SHIFT: begin
        cmd.op     = OP_SHIFT;
        state_next = status.n_odd ? ST_ROUND : ST_EMIT;
      end
      ST_ROUND: begin
        cmd.op     = OP_ROUND;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid || out_ready) begin
          cmd.op     = OP_EMIT;
          emit       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // output slot holds until taken
  assign out_valid_next = emit || (out_valid && !out_ready);
  assign in_ready       = (state == ST_IDLE);

endmodule

// ===== sv/vms_dp.sv =====
// datapath for vector_magnitude_sqrt: one shared 16x16 multiplier and work registers
// depends on vms_pkg; commanded by vms_ctrl
`timescale 1ns / 1ps

module vms_dp
  import vms_pkg::*;
(
  input  logic               clk,
  input  dp_cmd_t            cmd,
  input  logic signed [23:0] comp_x,
  input  logic signed [23:0] comp_y,
  output dp_status_t         status,
  output logic        [15:0] magnitude
);

  logic [15:0] mx, my;   // component magnitudes
  logic [31:0] s;        // sum, normalized sum, then correction residue
  logic [4:0]  n;        // normalize shift count
  logic [15:0] p;        // complemented top half of normalized sum
  logic [15:0] t;        // polynomial term
  logic [15:0] acc;      // polynomial accumulator
  logic [15:0] e;        // estimate
  logic [15:0] mul_a, mul_b;
  logic [31:0] prod;
  logic [15:0] sh18, sh17, sh16;
  logic [31:0] rnd;

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_SQ_X: begin
        mul_a = mx;
        mul_b = mx;
      end
      OP_SQ_Y: begin
        mul_a = my;
        mul_b = my;
      end
      OP_TP18, OP_TP17, OP_TP16: begin
        mul_a = t;
        mul_b = p;
      end
      OP_MUL_A: begin
        mul_a = t;
        mul_b = K_A000;
      end
      OP_EP: begin
        mul_a = e;
        mul_b = p;
      end
      OP_MUL_B: begin
        mul_a = e;
        mul_b = K_B333;
      end
      OP_SQ_E: begin
        mul_a = ~acc;
        mul_b = ~acc;
      end
      OP_ROUND: begin
        mul_a = e;
        mul_b = K_B505;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = 32'(mul_a) * 32'(mul_b);
  assign sh18 = {2'b00, prod[31:18]};
  assign sh17 = {1'b0, prod[31:17]};
  assign sh16 = prod[31:16];
  assign rnd  = prod + K_ROUND;

  // work registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        mx <= abs16(comp_x[23:8]);
        my <= abs16(comp_y[23:8]);
        n  <= '0;
      end
      OP_SQ_X: s <= prod;
      OP_SQ_Y: s <= s + prod;
      OP_NORM16: begin
        if (s[31:16] == '0) begin
          s <= s << 16;
          n <= n + 5'd16;
        end
      end
      OP_NORM8: begin
        if (s[31:24] == '0) begin
          s <= s << 8;
          n <= n + 5'd8;
        end
      end
      OP_NORM4: begin
        if (s[31:28] == '0) begin
          s <= s << 4;
          n <= n + 5'd4;
        end
      end
      OP_NORM2: begin
        if (s[31:30] == '0) begin
          s <= s << 2;
          n <= n + 5'd2;
        end
      end
      OP_NORM1: begin
        if (!s[31]) begin
          s <= s << 1;
          n <= n + 5'd1;
        end
      end
      OP_P_INIT: begin
        p   <= ~s[31:16];
        t   <= {1'b0, ~s[31:17]};
        acc <= {1'b0, ~s[31:17]};
      end
      OP_TP18: begin
        t   <= sh18;
        acc <= acc + sh18;
      end
      OP_TP17: begin
        t   <= sh17;
        acc <= acc + sh17;
      end
      OP_TP16: t <= sh16;
      OP_MUL_A: begin
        e   <= sh16;
        acc <= acc + sh16;
      end
      OP_EP: e <= sh16;
      OP_MUL_B: begin
        e   <= sh16;
        acc <= acc + sh16;
      end
      // residue of the normalized sum against the squared estimate
      OP_SQ_E: begin
        s <= s - prod;
        e <= ~acc;
      end
      // add residue shifted right arithmetically by 17
      OP_CORR:  e <= e + {s[31], s[31:17]};
      OP_SHIFT: e <= e >> n[4:1];
      OP_ROUND: e <= rnd[31:16];
      OP_SMALL: e <= s[15:0];
      OP_EMIT:  magnitude <= e;
      default: begin
      end
    endcase
  end

  assign status.s_small = (s[31:1] == '0);
  assign status.n_odd   = n[0];

endmodule

// ===== sv/vector_magnitude_sqrt.sv =====
// top level of vector_magnitude_sqrt: approximate length of a two-component vector
// depends on vms_pkg, vms_ctrl and vms_dp
//
// channel  | handshake            | payload
// ---------+----------------------+---------------------------------
// input    | in_valid / in_ready  | comp_x[23:0], comp_y[23:0] signed
// output   | out_valid / out_ready| magnitude[15:0]
//
// one item at a time; an item is squared, normalized, put through the polynomial,
// corrected, rescaled and, on an odd normalize shift count, rounded; a sum of 0
// or 1 goes straight to emit. the steps share one 16x16 multiplier doing one
// product per cycle and a five-step normalize shifter. in_ready is high again once
// the result is registered, so the next item can enter while it waits to be taken.
// synchronous reset clears the sequencer and output valid; a stalled output holds.
`timescale 1ns / 1ps

module vector_magnitude_sqrt
  import vms_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] comp_x,
  input  logic signed [23:0] comp_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic        [15:0] magnitude
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer
  vms_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // arithmetic
  vms_dp u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .comp_x    (comp_x),
    .comp_y    (comp_y),
    .status    (status),
    .magnitude (magnitude)
  );

endmodule

// ===== sv/vms_checker.sv =====
// port-level checks for vector_magnitude_sqrt, bound to the top level
// depends on vector_magnitude_sqrt_macros.svh
`timescale 1ns / 1ps
`include "vector_magnitude_sqrt_macros.svh"

module vms_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic        [15:0] magnitude
);

  logic in_acc;
  logic out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // a stalled result stays offered
  `VMS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  // a stalled result keeps its value
  `VMS_ASSERT_NEXT(a_mag_hold, clk, rst, out_valid && !out_ready, $stable(magnitude))
  // one item in flight: no new item right after one is taken
  `VMS_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_acc, !in_ready)
  // no result can follow an item in the very next cycle
  `VMS_ASSERT_NEXT(a_no_instant_result, clk, rst, in_acc && (!out_valid || out_acc), !out_valid)
  // a fresh result means the sequencer is back to taking items
  `VMS_ASSERT_IMPL(a_ready_with_result, clk, rst, $rose(out_valid), in_ready)

endmodule

bind vector_magnitude_sqrt vms_checker u_vms_checker (.*);

// ===== dv/tb_vector_magnitude_sqrt.sv =====
// self-checking testbench for vector_magnitude_sqrt
// depends on vms_pkg and the vector_magnitude_sqrt top level
`timescale 1ns / 1ps

module tb_vector_magnitude_sqrt;
  import vms_pkg::*;

  localparam logic [31:0] LOW16 = 32'h0000_FFFF;
  localparam int PHASES = 4;
  localparam int RANDOM_PER_PHASE = 350;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    logic signed [23:0] x;
    logic signed [23:0] y;
  } vec_item_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [23:0] comp_x = '0;
  logic signed [23:0] comp_y = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic        [15:0] magnitude;

  vec_item_t   vectors_to_send[$];
  logic [15:0] expected_mag[$];
  vec_item_t   next_vec;
  logic [15:0] want_mag;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          items_accepted = 0;
  int          results_checked = 0;
  int          small_sums = 0;
  int          odd_shifts = 0;
  int          error_count = 0;

  int send_pct_of_phase[PHASES] = '{0, 87, 0, 9};
  int recv_pct_of_phase[PHASES] = '{0, 0, 87, 9};

  vector_magnitude_sqrt u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .comp_x    (comp_x),
    .comp_y    (comp_y),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .magnitude (magnitude)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sum of squares of the components taken down to 16 bits
  function automatic logic [31:0] sum_of_squares(input logic signed [23:0] cx,
                                                 input logic signed [23:0] cy);
    logic signed [15:0] hx;
    logic signed [15:0] hy;
    int                 vx;
    int                 vy;
    logic        [31:0] ax;
    logic        [31:0] ay;
    hx = cx[23:8];
    hy = cy[23:8];
    vx = hx;
    vy = hy;
    ax = (vx < 0) ? 32'(-vx) : 32'(vx);
    ay = (vy < 0) ? 32'(-vy) : 32'(vy);
    return ax * ax + ay * ay;
  endfunction

  // normalize shift count of a sum of at least two
  function automatic int unsigned norm_shift(input logic [31:0] sum);
    logic [31:0] s;
    int unsigned n;
    s = sum;
    n = 0;
    while (s[31] == 1'b0) begin
      s = s << 1;
      n++;
    end
    return n;
  endfunction

  // expected length: polynomial root estimate, one correction, rescale
  function automatic logic [15:0] hypot_estimate(input logic signed [23:0] cx,
                                                 input logic signed [23:0] cy);
    logic        [31:0] s;
    logic        [31:0] p;
    logic        [31:0] t;
    logic        [31:0] acc;
    logic        [31:0] e;
    logic        [31:0] d;
    logic        [31:0] corr;
    int unsigned        n;
    s = sum_of_squares(cx, cy);
    if (s < 32'd2) return s[15:0];
    n = norm_shift(s);
    s = s << n;
    p = {16'h0000, ~s[31:16]};

    // polynomial in the complemented top half
    t = p >> 1;
    acc = t & LOW16;
    t = (t * p) >> 18;
    acc = (acc + t) & LOW16;
    t = (t * p) >> 17;
    acc = (acc + t) & LOW16;
    t = (t * p) >> 16;
    e = ((t * K_A000) >> 16) & LOW16;
    acc = (acc + e) & LOW16;
    e = ((e * p) >> 16) & LOW16;
    e = ((e * K_B333) >> 16) & LOW16;
    acc = (acc + e) & LOW16;

    // one correction step, wrapping 32-bit difference read as signed
    e = (acc ^ LOW16) & LOW16;
    d = s - e * e;
    corr = $signed(d) >>> 17;
    e = (e + corr) & LOW16;

    // undo the normalize shift, odd counts scaled by 1/sqrt2
    if (n[0]) e = ((((e >> (n >> 1)) * K_B505) + K_ROUND) >> 16) & LOW16;
    else e = e >> (n >> 1);
    return e[15:0];
  endfunction

  // random component: full range, scaled down, tiny, or an extreme
  function automatic logic signed [23:0] random_component();
    logic signed [23:0] r;
    r = 24'($urandom);
    case ($urandom_range(0, 7))
      0, 1: begin
      end
      2, 3, 4: begin
        r = r >>> $urandom_range(1, 23);
      end
      5: begin
        r = $urandom_range(0, 1) ? 24'sh800000 : 24'sh7FFFFF;
      end
      default: begin
        r = r >>> 14;
      end
    endcase
    return r;
  endfunction

  task automatic queue_vec(input logic signed [23:0] x, input logic signed [23:0] y);
    vec_item_t v;
    v.x = x;
    v.y = y;
    vectors_to_send.push_back(v);
  endtask

  // corner vectors: zero and unit sums, extremes, odd and even shifts, bit patterns
  task automatic queue_directed();
    queue_vec(24'sd0, 24'sd0);
    queue_vec(24'sd255, -24'sd1);
    queue_vec(24'sd256, 24'sd0);
    queue_vec(-24'sd256, 24'sd0);
    queue_vec(24'sd0, -24'sd255);
    queue_vec(24'sh800000, 24'sh800000);
    queue_vec(24'sh7FFFFF, 24'sh7FFFFF);
    queue_vec(24'sh800000, 24'sh7FFFFF);
    queue_vec(24'sh7FFFFF, 24'sd0);
    queue_vec(24'sd0, 24'sh800000);
    queue_vec(24'sd256, 24'sd256);
    queue_vec(24'sd512, 24'sd0);
    queue_vec(24'sd512, 24'sd512);
    queue_vec(-24'sd1, -24'sd1);
    queue_vec(24'sh555555, 24'shAAAAAA);
    queue_vec(24'shAAAAAA, 24'sh555555);
    queue_vec(24'sh123456, -24'sh0ABCDE);
    queue_vec(24'sh00FF00, 24'shFF00FF);
    queue_vec(24'sh400000, 24'sh400000);
    queue_vec(24'sh000300, -24'sh000400);
  endtask

  // driver: present the next vector once the current one is taken
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_mag.push_back(hypot_estimate(comp_x, comp_y));
        items_accepted++;
        if (sum_of_squares(comp_x, comp_y) < 32'd2) small_sums++;
        else if (norm_shift(sum_of_squares(comp_x, comp_y)) % 2 == 1) odd_shifts++;
      end
      if (!in_valid || in_ready) begin
        if (vectors_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_vec = vectors_to_send.pop_front();
          in_valid <= 1'b1;
          comp_x <= next_vec.x;
          comp_y <= next_vec.y;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each taken result against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_mag.size() == 0) begin
          error_count++;
          $display("%0t: unexpected magnitude item: expected none, actual %h",
                   $time, magnitude);
        end else begin
          want_mag = expected_mag.pop_front();
          results_checked++;
          if (magnitude !== want_mag) begin
            error_count++;
            $display("%0t: magnitude mismatch: expected %h, actual %h",
                     $time, want_mag, magnitude);
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // stimulus phases, each drained before the next starts
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < PHASES; ph++) begin
      send_idle_pct = send_pct_of_phase[ph];
      recv_stall_pct = recv_pct_of_phase[ph];
      if (ph == 0) queue_directed();
      for (int i = 0; i < RANDOM_PER_PHASE; i++) queue_vec(random_component(), random_component());
      while (vectors_to_send.size() != 0 || in_valid || expected_mag.size() != 0)
        @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (expected_mag.size() != 0) begin
      error_count++;
      $display("%0t: %0d magnitude items never arrived", $time, expected_mag.size());
    end
    $display("covered %0d vectors over %0d idle/stall phases, %0d results checked",
             items_accepted, PHASES, results_checked);
    $display("zero or unit sums: %0d, odd normalize shifts: %0d", small_sums, odd_shifts);
    if (error_count == 0) begin
      $display("tb_vector_magnitude_sqrt: clean");
    end else begin
      $display("tb_vector_magnitude_sqrt: errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("%0t: run did not finish in time", $time);
    $display("tb_vector_magnitude_sqrt: errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/vms_pkg.sv
sv/vms_ctrl.sv
sv/vms_dp.sv
sv/vector_magnitude_sqrt.sv
sv/vms_checker.sv
dv/tb_vector_magnitude_sqrt.sv
